/* hdl/cpf_pkg.sv */
// Package: shared types, constants and classification functions for the code point filter.
`default_nettype none
package cpf_pkg;

    localparam int CP_W         = 21;
    localparam int CNT_W        = 16;
    localparam int FLAGS_W      = 6;
    localparam logic [CNT_W-1:0] COUNT_CAP = 16'hFFFF;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_AW      = 1;

    localparam int F_CASE = 0;
    localparam int F_QUOT = 1;
    localparam int F_DASH = 2;
    localparam int F_RMCC = 3;
    localparam int F_RMWS = 4;
    localparam int F_RMDI = 5;

    localparam logic [7:0] APOSTROPHE = 8'h27;
    localparam logic [7:0] HYPHEN     = 8'h2D;

    localparam logic [0:0] REG_TYPE_FLAGS = 1'b0;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      nbytes;
        logic            eot;
        logic            mb;
    } cpf_rec_t;

    function automatic logic is_dash(input logic [CP_W-1:0] c);
        unique case (c)
            21'h0058A, 21'h005BE, 21'h01400, 21'h01806, 21'h02010, 21'h02011,
            21'h02012, 21'h02013, 21'h02014, 21'h02015, 21'h02053, 21'h0207B,
            21'h0208B, 21'h02212, 21'h02E17, 21'h02E1A, 21'h02E3A, 21'h02E3B,
            21'h02E40, 21'h0301C, 21'h03030, 21'h030A0, 21'h0FE31, 21'h0FE32,
            21'h0FE58, 21'h0FE63, 21'h0FF0D: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_quote(input logic [CP_W-1:0] c);
        unique case (c)
            21'h000AB, 21'h000BB, 21'h02018, 21'h02019, 21'h0201A, 21'h0201B,
            21'h0201C, 21'h0201D, 21'h0201E, 21'h0201F, 21'h02039, 21'h0203A,
            21'h02E42, 21'h0300C, 21'h0300D, 21'h0300E, 21'h0300F, 21'h0301D,
            21'h0301E, 21'h0301F, 21'h0FE41, 21'h0FE42, 21'h0FE43, 21'h0FE44,
            21'h0FF02, 21'h0FF07, 21'h0FF62, 21'h0FF63: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_space(input logic [CP_W-1:0] c);
        logic hit;
        hit = (c >= 21'h02000 && c <= 21'h0200A);
        unique case (c)
            21'h000A0, 21'h01680, 21'h02028, 21'h02029, 21'h0202F, 21'h0205F,
            21'h03000: hit = 1'b1;
            default: ;
        endcase
        return hit;
    endfunction

    function automatic logic is_ignorable(input logic [CP_W-1:0] c);
        logic hit;
        hit = (c >= 21'h0180B && c <= 21'h0180E) ||
              (c >= 21'h0200B && c <= 21'h0200F) ||
              (c >= 21'h0202A && c <= 21'h0202E) ||
              (c >= 21'h02060 && c <= 21'h0206F) ||
              (c >= 21'h0FE00 && c <= 21'h0FE0F) ||
              (c >= 21'h0FFF0 && c <= 21'h0FFF8) ||
              (c >= 21'h1BCA0 && c <= 21'h1BCA3) ||
              (c >= 21'h1D173 && c <= 21'h1D17A);
        unique case (c)
            21'h000AD, 21'h0034F, 21'h0061C, 21'h0115F, 21'h01160, 21'h017B4,
            21'h017B5, 21'h03164, 21'h0FEFF, 21'h0FFA0: hit = 1'b1;
            default: ;
        endcase
        return hit;
    endfunction

endpackage
`default_nettype wire

/* hdl/cpf_front.sv */
// Front end: filters and folds each code point and encodes it as a UTF-8 record.
`default_nettype none
module cpf_front (
    input  wire logic                        push,
    input  wire logic [cpf_pkg::CP_W-1:0]    code_point,
    input  wire logic                        end_of_token,
    input  wire logic [cpf_pkg::FLAGS_W-1:0] flags,
    input  wire logic                        q_full,
    output logic                             q_wr,
    output cpf_pkg::cpf_rec_t                q_rec
);
    import cpf_pkg::*;

    logic            keep;
    logic [CP_W-1:0] mapped;
    logic            accept;

    assign accept = push && !q_full;

    always_comb
    begin
        keep   = 1'b1;
        mapped = code_point;
        if (code_point <= 21'h7F)
        begin
            if (flags[F_RMCC] && (code_point <= 21'h08 ||
                (code_point >= 21'h0E && code_point <= 21'h1F) || code_point == 21'h7F))
                keep = 1'b0;
            if (flags[F_RMWS] && ((code_point >= 21'h09 && code_point <= 21'h0D) ||
                code_point == 21'h20))
                keep = 1'b0;
            if (flags[F_CASE] && code_point >= 21'h41 && code_point <= 21'h5A)
                mapped = code_point + 21'h20;
            if (flags[F_QUOT] && code_point == 21'h22)
                mapped = {13'd0, APOSTROPHE};
        end
        else if (code_point <= 21'h9F)
        begin
            if (code_point == 21'h85)
                keep = !flags[F_RMWS];
            else
                keep = !flags[F_RMCC];
        end
        else if (code_point <= 21'hDFFFF)
        begin
            if (is_dash(code_point))
            begin
                if (flags[F_DASH])
                    mapped = {13'd0, HYPHEN};
            end
            else if (is_quote(code_point))
            begin
                if (flags[F_QUOT])
                    mapped = {13'd0, APOSTROPHE};
            end
            else if (is_space(code_point))
                keep = !flags[F_RMWS];
            else if (is_ignorable(code_point))
                keep = !flags[F_RMDI];
        end
        else if (code_point <= 21'hE0FFF)
            keep = !flags[F_RMDI];
    end

    always_comb
    begin
        q_rec.bytes  = '0;
        q_rec.eot    = end_of_token;
        q_rec.mb     = keep && (mapped >= 21'h80);
        if (!keep)
            q_rec.nbytes = 3'd0;
        else if (mapped < 21'h80)
        begin
            q_rec.nbytes   = 3'd1;
            q_rec.bytes[0] = mapped[7:0];
        end
        else if (mapped < 21'h800)
        begin
            q_rec.nbytes   = 3'd2;
            q_rec.bytes[0] = {3'b110, mapped[10:6]};
            q_rec.bytes[1] = {2'b10, mapped[5:0]};
        end
        else if (mapped < 21'h10000)
        begin
            q_rec.nbytes   = 3'd3;
            q_rec.bytes[0] = {4'b1110, mapped[15:12]};
            q_rec.bytes[1] = {2'b10, mapped[11:6]};
            q_rec.bytes[2] = {2'b10, mapped[5:0]};
        end
        else
        begin
            q_rec.nbytes   = 3'd4;
            q_rec.bytes[0] = {5'b11110, mapped[20:18]};
            q_rec.bytes[1] = {2'b10, mapped[17:12]};
            q_rec.bytes[2] = {2'b10, mapped[11:6]};
            q_rec.bytes[3] = {2'b10, mapped[5:0]};
        end
    end

    // an item that is dropped and closes no token leaves nothing behind
    assign q_wr = accept && (keep || end_of_token);

endmodule
`default_nettype wire

/* hdl/cpf_fifo.sv */
// Short record queue between front end and back end.
`default_nettype none
module cpf_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr,
    input  wire cpf_pkg::cpf_rec_t  wr_rec,
    input  wire logic               rd,
    output cpf_pkg::cpf_rec_t       rd_rec,
    output logic                    full,
    output logic                    empty
);
    import cpf_pkg::*;

    cpf_rec_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     cnt_reg, cnt_next;
    logic                 do_wr, do_rd;

    assign full   = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_rec = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_rec;
    end

endmodule
`default_nettype wire

/* hdl/cpf_back.sv */
// Back end: a byte per cycle while fed and popped; tracks tokens, emits summaries.
`default_nettype none
module cpf_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cpf_pkg::cpf_rec_t          q_rec,
    input  wire logic                       q_empty,
    output logic                            q_rd,
    input  wire logic                       pop,
    output logic                            empty,
    output logic [7:0]                      out_byte,
    output logic                            is_summary,
    output logic [cpf_pkg::CNT_W-1:0]       token_bytes,
    output logic                            token_has_multibyte,
    output logic                            last
);
    import cpf_pkg::*;

    logic [2:0]       idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             mbseen_reg, mbseen_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             summ_reg, summ_next;
    logic [CNT_W-1:0] tbytes_reg, tbytes_next;
    logic             tmb_reg, tmb_next;
    logic             last_reg, last_next;

    logic [2:0] total;
    logic       can_load, gen_fire, gen_summary, gen_last;

    assign total       = q_rec.nbytes + 3'(q_rec.eot);
    assign can_load    = !valid_reg || pop;
    assign gen_fire    = !q_empty && can_load;
    assign gen_summary = (idx_reg == q_rec.nbytes);
    assign gen_last    = (idx_reg == total - 3'd1);
    assign q_rd        = gen_fire && gen_last;

    always_comb
    begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        mbseen_next = mbseen_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        summ_next   = summ_reg;
        tbytes_next = tbytes_reg;
        tmb_next    = tmb_reg;
        last_next   = last_reg;
        if (gen_fire)
        begin
            valid_next = 1'b1;
            last_next  = gen_last;
            idx_next   = gen_last ? 3'd0 : idx_reg + 3'd1;
            if (gen_summary)
            begin
                byte_next   = 8'd0;
                summ_next   = 1'b1;
                tbytes_next = count_reg;
                tmb_next    = mbseen_reg;
                count_next  = '0;
                mbseen_next = 1'b0;
            end
            else
            begin
                byte_next   = q_rec.bytes[idx_reg[1:0]];
                summ_next   = 1'b0;
                tbytes_next = '0;
                tmb_next    = 1'b0;
                if (count_reg < COUNT_CAP)
                    count_next = count_reg + 1'b1;
                if (q_rec.mb)
                    mbseen_next = 1'b1;
            end
        end
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            count_reg  <= '0;
            mbseen_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            mbseen_reg <= mbseen_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        summ_reg   <= summ_next;
        tbytes_reg <= tbytes_next;
        tmb_reg    <= tmb_next;
        last_reg   <= last_next;
    end

    assign empty               = !valid_reg;
    assign out_byte            = byte_reg;
    assign is_summary          = summ_reg;
    assign token_bytes         = tbytes_reg;
    assign token_has_multibyte = tmb_reg;
    assign last                = last_reg;

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && summ_reg) |-> (last_reg && byte_reg == 8'd0))
        else $error("summary item not marked last");

    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !summ_reg) |-> (tbytes_reg == '0 && !tmb_reg))
        else $error("byte item carries summary fields");

    a_token_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_fire && gen_summary) |=> (count_reg == '0 && !mbseen_reg))
        else $error("token state not cleared after summary");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (idx_reg < total))
        else $error("record index out of range");

endmodule
`default_nettype wire

/* hdl/code_point_filter_fold_utf8.sv */
// Top level: configuration register, front end, record queue and back end.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | push / full        | code_point[20:0], end_of_token
//  result   | pop / empty        | out_byte, is_summary, token_bytes, token_has_multibyte, last
//  config   | psel/penable/pwrite| paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
//  One result per cycle leaves the back end while pop keeps up and the queue holds a
//  record; an item yields up to four bytes plus a summary. Classification and encoding
//  are combinational; a two-entry queue decouples input from output. Reset clears
//  flags, token state and queue; a stalled pop holds the result register while the
//  front keeps filling the queue.
`default_nettype none
module code_point_filter_fold_utf8 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [cpf_pkg::CP_W-1:0]    code_point,
    input  wire logic                        end_of_token,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [7:0]                       out_byte,
    output logic                             is_summary,
    output logic [cpf_pkg::CNT_W-1:0]        token_bytes,
    output logic                             token_has_multibyte,
    output logic                             last,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import cpf_pkg::*;

    logic [FLAGS_W-1:0] flags_reg, flags_next;
    logic               cfg_wr;
    logic               q_wr, q_rd, q_full, q_empty;
    cpf_rec_t           wr_rec, rd_rec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        flags_next = flags_reg;
        if (cfg_wr && paddr[2] == REG_TYPE_FLAGS)
            flags_next = pwdata[FLAGS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= '0;
        else
            flags_reg <= flags_next;
    end

    assign prdata = (paddr[2] == REG_TYPE_FLAGS) ? {(32-FLAGS_W)'(0), flags_reg} : 32'd0;
    assign full   = q_full;

    cpf_front u_front (
        .push         (push),
        .code_point   (code_point),
        .end_of_token (end_of_token),
        .flags        (flags_reg),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_rec        (wr_rec)
    );

    cpf_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (q_wr),
        .wr_rec (wr_rec),
        .rd     (q_rd),
        .rd_rec (rd_rec),
        .full   (q_full),
        .empty  (q_empty)
    );

    cpf_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_rec               (rd_rec),
        .q_empty             (q_empty),
        .q_rd                (q_rd),
        .pop                 (pop),
        .empty               (empty),
        .out_byte            (out_byte),
        .is_summary          (is_summary),
        .token_bytes         (token_bytes),
        .token_has_multibyte (token_has_multibyte),
        .last                (last)
    );

endmodule
`default_nettype wire
